@@ rtl/core/etfp_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// etfp_pkg
// Shared types, constants and helpers of the escape-time fractal pixel engine.
// ----------------------------------------------------------------------------
package etfp_pkg;

    localparam int DATA_W      = 32;
    localparam int WIDE_W      = 64;
    localparam int COUNT_W     = 16;
    localparam int COORD_W     = 10;
    localparam int PITCH_W     = 31;
    localparam int DIFF_W      = 14;
    localparam int PROD_W      = DIFF_W + DATA_W;
    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 32;

    localparam logic [CFG_INDEX_W-1:0] CFG_FRACTAL_KIND     = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_ITERATION_LIMIT  = 8'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_PITCH_REAL       = 8'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_PITCH_IMAG       = 8'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_CENTER_REAL      = 8'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_CENTER_IMAG      = 8'd5;
    localparam logic [CFG_INDEX_W-1:0] CFG_JULIA_CONST_REAL = 8'd6;
    localparam logic [CFG_INDEX_W-1:0] CFG_JULIA_CONST_IMAG = 8'd7;

    localparam logic KIND_MANDELBROT = 1'b0;
    localparam logic KIND_JULIA      = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MAP_MUL,
        ST_MAP_ADD,
        ST_ITER_MUL,
        ST_ITER_UPD,
        ST_FINISH
    } t_state;

    typedef struct packed {
        logic                      fractal_kind;
        logic [COUNT_W-1:0]        iteration_limit;
        logic [PITCH_W-1:0]        pitch_real;
        logic [PITCH_W-1:0]        pitch_imag;
        logic signed [DATA_W-1:0]  center_real;
        logic signed [DATA_W-1:0]  center_imag;
        logic signed [DATA_W-1:0]  julia_const_real;
        logic signed [DATA_W-1:0]  julia_const_imag;
    } t_cfg;

    typedef struct packed {
        logic load_pixel;
        logic map_mul;
        logic map_add;
        logic iter_mul;
        logic iter_upd;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic limit_zero;
        logic escaped;
        logic last_iter;
    } t_dp_status;

    function automatic logic signed [DATA_W-1:0] sat_word(input logic signed [WIDE_W-1:0] v);
        logic signed [WIDE_W-1:0] hi;
        logic signed [WIDE_W-1:0] lo;
        hi = 64'sd2147483647;
        lo = -64'sd2147483648;
        if (v > hi) begin
            return {1'b0, {(DATA_W-1){1'b1}}};
        end else if (v < lo) begin
            return {1'b1, {(DATA_W-1){1'b0}}};
        end else begin
            return v[DATA_W-1:0];
        end
    endfunction

endpackage
`default_nettype wire

@@ rtl/core/etfp_cfg_regs.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// etfp_cfg_regs
// Configuration register file, written through its own request channel.
// ----------------------------------------------------------------------------
module etfp_cfg_regs (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cfg_valid,
    input  wire logic [etfp_pkg::CFG_INDEX_W-1:0]    i_cfg_index,
    input  wire logic [etfp_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    output etfp_pkg::t_cfg                           o_cfg
);

    etfp_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.fractal_kind     <= etfp_pkg::KIND_MANDELBROT;
            r_cfg.iteration_limit  <= 16'd100;
            r_cfg.pitch_real       <= 31'd2097152;
            r_cfg.pitch_imag       <= 31'd2097152;
            r_cfg.center_real      <= '0;
            r_cfg.center_imag      <= '0;
            r_cfg.julia_const_real <= '0;
            r_cfg.julia_const_imag <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                etfp_pkg::CFG_FRACTAL_KIND:     r_cfg.fractal_kind     <= i_cfg_data[0];
                etfp_pkg::CFG_ITERATION_LIMIT:  r_cfg.iteration_limit  <= i_cfg_data[15:0];
                etfp_pkg::CFG_PITCH_REAL:       r_cfg.pitch_real       <= i_cfg_data[30:0];
                etfp_pkg::CFG_PITCH_IMAG:       r_cfg.pitch_imag       <= i_cfg_data[30:0];
                etfp_pkg::CFG_CENTER_REAL:      r_cfg.center_real      <= $signed(i_cfg_data);
                etfp_pkg::CFG_CENTER_IMAG:      r_cfg.center_imag      <= $signed(i_cfg_data);
                etfp_pkg::CFG_JULIA_CONST_REAL: r_cfg.julia_const_real <= $signed(i_cfg_data);
                etfp_pkg::CFG_JULIA_CONST_IMAG: r_cfg.julia_const_imag <= $signed(i_cfg_data);
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule
`default_nettype wire

@@ rtl/core/etfp_datapath.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// etfp_datapath
// Point mapping, z squared plus c iteration and result register.
// ----------------------------------------------------------------------------
module etfp_datapath #(
    parameter int IMAGE_WIDTH   = 1024,
    parameter int IMAGE_HEIGHT  = 1024,
    parameter int FRACTION_BITS = 28
) (
    input  wire logic                                i_clk,
    input  wire etfp_pkg::t_cfg                      i_cfg,
    input  wire etfp_pkg::t_dp_cmd                   i_cmd,
    output etfp_pkg::t_dp_status                     o_status,
    input  wire logic [etfp_pkg::COORD_W-1:0]        i_column,
    input  wire logic [etfp_pkg::COORD_W-1:0]        i_row,
    output logic [etfp_pkg::COORD_W-1:0]             o_out_column,
    output logic [etfp_pkg::COORD_W-1:0]             o_out_row,
    output logic [etfp_pkg::COUNT_W-1:0]             o_escape_count,
    output logic                                     o_bounded
);

    localparam int DATA_W  = etfp_pkg::DATA_W;
    localparam int WIDE_W  = etfp_pkg::WIDE_W;
    localparam int DIFF_W  = etfp_pkg::DIFF_W;
    localparam int PROD_W  = etfp_pkg::PROD_W;
    localparam int COORD_W = etfp_pkg::COORD_W;
    localparam int COUNT_W = etfp_pkg::COUNT_W;

    localparam logic signed [DIFF_W-1:0] HALF_RE = DIFF_W'(IMAGE_WIDTH / 2);
    localparam logic signed [DIFF_W-1:0] HALF_IM = DIFF_W'(IMAGE_HEIGHT / 2);
    localparam logic signed [WIDE_W-1:0] LIMIT4  = 64'sd4 <<< FRACTION_BITS;

    logic [COORD_W-1:0]        r_column;
    logic [COORD_W-1:0]        r_row;
    logic signed [PROD_W-1:0]  r_prod_re;
    logic signed [PROD_W-1:0]  r_prod_im;
    logic signed [DATA_W-1:0]  r_zr;
    logic signed [DATA_W-1:0]  r_zi;
    logic signed [DATA_W-1:0]  r_cr;
    logic signed [DATA_W-1:0]  r_ci;
    logic signed [WIDE_W-1:0]  r_sq_re;
    logic signed [WIDE_W-1:0]  r_sq_im;
    logic signed [WIDE_W-1:0]  r_cross;
    logic [COUNT_W-1:0]        r_count;
    logic [COORD_W-1:0]        r_out_column;
    logic [COORD_W-1:0]        r_out_row;
    logic [COUNT_W-1:0]        r_out_count;
    logic                      r_out_bounded;

    logic signed [DIFF_W-1:0]  w_d_re;
    logic signed [DIFF_W-1:0]  w_d_im;
    logic signed [PROD_W-1:0]  w_pitch_re;
    logic signed [PROD_W-1:0]  w_pitch_im;
    logic signed [DATA_W-1:0]  w_map_re;
    logic signed [DATA_W-1:0]  w_map_im;
    logic signed [WIDE_W-1:0]  w_sr;
    logic signed [WIDE_W-1:0]  w_si;
    logic signed [WIDE_W-1:0]  w_sum;
    logic signed [DATA_W-1:0]  w_next_zr;
    logic signed [DATA_W-1:0]  w_next_zi;
    logic [COUNT_W:0]          w_count_inc;

    // point mapping
    assign w_d_re     = $signed({{(DIFF_W-COORD_W){1'b0}}, r_column}) - HALF_RE;
    assign w_d_im     = $signed({{(DIFF_W-COORD_W){1'b0}}, r_row}) - HALF_IM;
    assign w_pitch_re = $signed({{(PROD_W-etfp_pkg::PITCH_W){1'b0}}, i_cfg.pitch_real});
    assign w_pitch_im = $signed({{(PROD_W-etfp_pkg::PITCH_W){1'b0}}, i_cfg.pitch_imag});

    assign w_map_re = etfp_pkg::sat_word(WIDE_W'(r_prod_re >>> FRACTION_BITS)
                                         + WIDE_W'(i_cfg.center_real));
    assign w_map_im = etfp_pkg::sat_word(WIDE_W'(r_prod_im >>> FRACTION_BITS)
                                         + WIDE_W'(i_cfg.center_imag));

    // iteration update
    assign w_sr        = r_sq_re >>> FRACTION_BITS;
    assign w_si        = r_sq_im >>> FRACTION_BITS;
    assign w_sum       = w_sr + w_si;
    assign w_next_zr   = etfp_pkg::sat_word(w_sr - w_si + WIDE_W'(r_cr));
    assign w_next_zi   = etfp_pkg::sat_word((r_cross >>> (FRACTION_BITS - 1)) + WIDE_W'(r_ci));
    assign w_count_inc = {1'b0, r_count} + 1'b1;

    assign o_status.limit_zero = (i_cfg.iteration_limit == '0);
    assign o_status.escaped    = (w_sum > LIMIT4);
    assign o_status.last_iter  = (w_count_inc == {1'b0, i_cfg.iteration_limit});

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_pixel) begin
            r_column <= i_column;
            r_row    <= i_row;
        end
        if (i_cmd.map_mul) begin
            r_prod_re <= PROD_W'(w_d_re) * w_pitch_re;
            r_prod_im <= PROD_W'(w_d_im) * w_pitch_im;
        end
        if (i_cmd.map_add) begin
            r_count <= '0;
            if (i_cfg.fractal_kind == etfp_pkg::KIND_JULIA) begin
                r_zr <= w_map_re;
                r_zi <= w_map_im;
                r_cr <= i_cfg.julia_const_real;
                r_ci <= i_cfg.julia_const_imag;
            end else begin
                r_zr <= '0;
                r_zi <= '0;
                r_cr <= w_map_re;
                r_ci <= w_map_im;
            end
        end
        if (i_cmd.iter_mul) begin
            r_sq_re <= r_zr * r_zr;
            r_sq_im <= r_zi * r_zi;
            r_cross <= r_zr * r_zi;
        end
        if (i_cmd.iter_upd && !o_status.escaped) begin
            r_zr    <= w_next_zr;
            r_zi    <= w_next_zi;
            r_count <= w_count_inc[COUNT_W-1:0];
        end
        if (i_cmd.out_load) begin
            r_out_column  <= r_column;
            r_out_row     <= r_row;
            r_out_count   <= r_count;
            r_out_bounded <= (r_count == i_cfg.iteration_limit);
        end
    end

    assign o_out_column   = r_out_column;
    assign o_out_row      = r_out_row;
    assign o_escape_count = r_out_count;
    assign o_bounded      = r_out_bounded;

endmodule
`default_nettype wire

@@ rtl/core/etfp_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// etfp_ctrl
// Sequencer for mapping and iteration, plus result valid flag.
// ----------------------------------------------------------------------------
module etfp_ctrl (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    input  wire etfp_pkg::t_dp_status i_status,
    output etfp_pkg::t_dp_cmd         o_cmd
);

    etfp_pkg::t_state r_state;
    etfp_pkg::t_state n_state;
    logic             r_out_valid;
    logic             n_out_valid;
    logic             w_out_free;

    assign w_out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            etfp_pkg::ST_IDLE: begin
                if (i_in_valid) n_state = etfp_pkg::ST_MAP_MUL;
            end
            etfp_pkg::ST_MAP_MUL: n_state = etfp_pkg::ST_MAP_ADD;
            etfp_pkg::ST_MAP_ADD: begin
                n_state = i_status.limit_zero ? etfp_pkg::ST_FINISH : etfp_pkg::ST_ITER_MUL;
            end
            etfp_pkg::ST_ITER_MUL: n_state = etfp_pkg::ST_ITER_UPD;
            etfp_pkg::ST_ITER_UPD: begin
                if (i_status.escaped || i_status.last_iter) begin
                    n_state = etfp_pkg::ST_FINISH;
                end else begin
                    n_state = etfp_pkg::ST_ITER_MUL;
                end
            end
            etfp_pkg::ST_FINISH: begin
                if (w_out_free) n_state = etfp_pkg::ST_IDLE;
            end
            default: n_state = etfp_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            etfp_pkg::ST_IDLE: begin
                o_in_ready       = 1'b1;
                o_cmd.load_pixel = i_in_valid;
            end
            etfp_pkg::ST_MAP_MUL:  o_cmd.map_mul  = 1'b1;
            etfp_pkg::ST_MAP_ADD:  o_cmd.map_add  = 1'b1;
            etfp_pkg::ST_ITER_MUL: o_cmd.iter_mul = 1'b1;
            etfp_pkg::ST_ITER_UPD: o_cmd.iter_upd = 1'b1;
            etfp_pkg::ST_FINISH:   o_cmd.out_load = w_out_free;
            default: begin
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= etfp_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

    a_accept_starts_map: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == etfp_pkg::ST_MAP_MUL))
        else $error("accepted pixel did not start mapping");

    a_load_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |=> o_out_valid)
        else $error("result load did not raise valid");

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> o_out_valid)
        else $error("pending result dropped");

    a_iter_loops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == etfp_pkg::ST_ITER_UPD) && !i_status.escaped && !i_status.last_iter)
        |=> (r_state == etfp_pkg::ST_ITER_MUL))
        else $error("iteration ended early");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> (!r_out_valid || i_out_ready))
        else $error("result overwritten before taken");

endmodule
`default_nettype wire

@@ rtl/core/escape_time_fractal_pixel.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// escape_time_fractal_pixel
// Maps a pixel to a complex point and counts z squared plus c iterations
// until escape or the iteration limit (Mandelbrot or Julia, fixed point).
//
//  channel  direction  handshake                  payload
//  pixel    in         i_valid / o_ready          i_column, i_row
//  result   out        o_valid / i_ready          o_out_column, o_out_row,
//                                                 o_escape_count, o_bounded
//  config   in         i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
//  each iteration forms three parallel 32x32 products, then runs the escape test
//  and the saturated update; a zero iteration limit skips iteration entirely
//  one pixel in flight; next pixel taken while a result waits in the output register
//  synchronous active-low reset restores configuration register defaults and idles the sequencer
//  a stalled result holds the sequencer in its finish state
// ----------------------------------------------------------------------------
module escape_time_fractal_pixel #(
    parameter int IMAGE_WIDTH   = 1024,
    parameter int IMAGE_HEIGHT  = 1024,
    parameter int FRACTION_BITS = 28
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_valid,
    output logic                                     o_ready,
    input  wire logic [etfp_pkg::COORD_W-1:0]        i_column,
    input  wire logic [etfp_pkg::COORD_W-1:0]        i_row,
    output logic                                     o_valid,
    input  wire logic                                i_ready,
    output logic [etfp_pkg::COORD_W-1:0]             o_out_column,
    output logic [etfp_pkg::COORD_W-1:0]             o_out_row,
    output logic [etfp_pkg::COUNT_W-1:0]             o_escape_count,
    output logic                                     o_bounded,
    input  wire logic                                i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  wire logic [etfp_pkg::CFG_INDEX_W-1:0]    i_cfg_index,
    input  wire logic [etfp_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    etfp_pkg::t_cfg       w_cfg;
    etfp_pkg::t_dp_cmd    w_cmd;
    etfp_pkg::t_dp_status w_status;

    assign o_cfg_ready = 1'b1;

    etfp_cfg_regs u_cfg_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    etfp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_valid),
        .o_in_ready  (o_ready),
        .o_out_valid (o_valid),
        .i_out_ready (i_ready),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    etfp_datapath #(
        .IMAGE_WIDTH   (IMAGE_WIDTH),
        .IMAGE_HEIGHT  (IMAGE_HEIGHT),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_cfg          (w_cfg),
        .i_cmd          (w_cmd),
        .o_status       (w_status),
        .i_column       (i_column),
        .i_row          (i_row),
        .o_out_column   (o_out_column),
        .o_out_row      (o_out_row),
        .o_escape_count (o_escape_count),
        .o_bounded      (o_bounded)
    );

endmodule
`default_nettype wire
